[sv/dom_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dom_pkg: shared types and constants of the depth outlier median tracker
// Widths, register indexes, state encodings and index helpers.
// ----------------------------------------------------------------------------
package dom_pkg;

    localparam int HISTORY_DEPTH = 8;
    localparam int IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

    localparam int MM_W       = 16;
    localparam int JUMP_W     = 16;
    localparam int STREAK_W   = 8;
    localparam int LEN_W      = 4;
    localparam int LOST_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [MM_W-1:0]  mm_t;

    localparam logic [IDX_W:0]      DEPTH_IDX  = (IDX_W + 1)'(HISTORY_DEPTH);
    localparam cnt_t                DEPTH_CNT  = CNT_W'(HISTORY_DEPTH);
    localparam logic [STREAK_W-1:0] STREAK_MAX = '1;
    localparam logic [LOST_W-1:0]   LOST_MAX   = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_JUMP  = 2'd0,
        CFG_STREAK    = 2'd1,
        CFG_HIST_LEN  = 2'd2,
        CFG_LOST_TOL  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        TRK_TRACK     = 2'd0,
        TRK_HOLD      = 2'd1,
        TRK_NO_DEPTH  = 2'd2,
        TRK_NO_TARGET = 2'd3
    } trk_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MED_CMP,
        ST_JUDGE,
        ST_MED_HELD,
        ST_EMIT
    } ctl_state_t;

    typedef enum logic [1:0] {
        M_IDLE,
        M_RD,
        M_CMP,
        M_CHECK
    } med_state_t;

    typedef struct packed {
        logic start;
        cnt_t count;
        idx_t head;
    } med_ctrl_t;

    typedef struct packed {
        logic done;
        mm_t  median;
    } med_stat_t;

    // circular buffer address: base + off, wrapped at the history depth
    function automatic idx_t wrap_add(idx_t base, idx_t off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_IDX)
        begin
            sum = sum - DEPTH_IDX;
        end
        return sum[IDX_W-1:0];
    endfunction

    // history length clipped to 1 .. depth
    function automatic cnt_t eff_len(logic [LEN_W-1:0] len);
        cnt_t n;
        if (len == '0)
        begin
            n = CNT_W'(1);
        end
        else if (int'(len) > HISTORY_DEPTH)
        begin
            n = DEPTH_CNT;
        end
        else
        begin
            n = CNT_W'(len);
        end
        return n;
    endfunction

endpackage

[sv/dom_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dom_in_if: input request channel
// One frame request: target flag, reading flag and raw depth.
// ----------------------------------------------------------------------------
interface dom_in_if import dom_pkg::*; ();
    logic valid;
    logic ready;
    logic target_seen;
    logic reading_valid;
    mm_t  raw_mm;

    modport source (output valid, output target_seen, output reading_valid,
                    output raw_mm, input ready);
    modport sink   (input valid, input target_seen, input reading_valid,
                    input raw_mm, output ready);
endinterface

[sv/dom_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dom_out_if: result request channel
// One result per frame: tracking state and filtered distance.
// ----------------------------------------------------------------------------
interface dom_out_if import dom_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] track_state;
    mm_t        filtered_mm;

    modport source (output valid, output track_state, output filtered_mm, input ready);
    modport sink   (input valid, input track_state, input filtered_mm, output ready);
endinterface

[sv/depth_outlier_median_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_outlier_median_tracker: median depth filter with outlier rejection
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    target_seen, reading_valid, raw_mm
//   out_ch   out  valid/ready    track_state, filtered_mm
//   cfg      in   cfg_we         cfg_index, cfg_data
//
// A request without a reading is accepted and then emitted. A reading on an
// empty history runs one median pass over one entry. Other readings run the
// shared median unit on the n entries of the history; unless the reading is
// an outlier short of the streak limit, the history is then updated and a
// second pass runs (over one entry after a restart). A pass uses the single
// compare pair and its RAM read ports. in_ch.ready is high only while idle; a
// result waits in the output register without blocking the next request until
// that request has its own result to emit. Reset clears all control state.
// ----------------------------------------------------------------------------
module depth_outlier_median_tracker import dom_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    dom_in_if.sink                in_ch,
    dom_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [JUMP_W-1:0]   max_jump_reg;
    logic [STREAK_W-1:0] streak_tol_reg;
    logic [LEN_W-1:0]    hist_len_reg;
    logic [LOST_W-1:0]   lost_tol_reg;

    // control and tracking state
    ctl_state_t          state_reg, state_next;
    cnt_t                count_reg, count_next;
    idx_t                head_reg, head_next;
    logic [STREAK_W-1:0] streak_reg, streak_next;
    logic [LOST_W-1:0]   lost_reg, lost_next;
    mm_t                 held_reg, held_next;
    logic                got_reg, got_next;
    logic                start_reg, start_next;
    logic                out_valid_reg, out_valid_next;

    // payload
    logic                seen_reg, seen_next;
    mm_t                 raw_reg, raw_next;
    mm_t                 med_reg, med_next;
    trk_state_t          out_state_reg, out_state_next;
    mm_t                 out_mm_reg, out_mm_next;

    // history RAM and median unit
    logic      wr_en;
    idx_t      wr_addr;
    mm_t       wr_data;
    idx_t      rd_addr_a;
    idx_t      rd_addr_b;
    mm_t       rd_data_a;
    mm_t       rd_data_b;
    med_ctrl_t med_ctrl;
    med_stat_t med_stat;

    // decisions
    logic                in_fire;
    logic                has_reading;
    logic                can_emit;
    mm_t                 abs_diff;
    logic                outlier;
    logic [STREAK_W-1:0] streak_inc;
    logic                streak_hit;
    logic [LOST_W-1:0]   lost_inc;
    logic                drop;
    cnt_t                eff;
    logic [CNT_W:0]      count_p1;
    logic                push_full;
    idx_t                head_adv;

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.track_state = out_state_reg;
    assign out_ch.filtered_mm = out_mm_reg;

    assign in_fire     = in_ch.valid && (state_reg == ST_IDLE);
    assign has_reading = in_ch.target_seen && in_ch.reading_valid;
    assign can_emit    = !out_valid_reg || out_ch.ready;

    assign abs_diff   = (raw_reg >= med_reg) ? (raw_reg - med_reg) : (med_reg - raw_reg);
    assign outlier    = abs_diff > max_jump_reg;
    assign streak_inc = (streak_reg == STREAK_MAX) ? streak_reg
                                                   : streak_reg + STREAK_W'(1);
    assign streak_hit = streak_inc >= streak_tol_reg;
    assign lost_inc   = (lost_reg == LOST_MAX) ? lost_reg : lost_reg + LOST_W'(1);
    assign drop       = (lost_inc >= lost_tol_reg) || (held_reg == '0);

    assign eff       = eff_len(hist_len_reg);
    assign count_p1  = {1'b0, count_reg} + (CNT_W + 1)'(1);
    assign push_full = (count_p1 > {1'b0, eff}) || (count_reg >= DEPTH_CNT);
    assign head_adv  = wrap_add(head_reg, IDX_W'(1));

    assign med_ctrl.start = start_reg;
    assign med_ctrl.count = count_reg;
    assign med_ctrl.head  = head_reg;

    dom_hist_ram u_ram
    (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    dom_median u_median
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (med_ctrl),
        .stat      (med_stat),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!has_reading)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_MED_HELD;
                    end
                    else
                    begin
                        state_next = ST_MED_CMP;
                    end
                end
            end
            ST_MED_CMP:
            begin
                if (med_stat.done)
                begin
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE:
            begin
                state_next = (outlier && !streak_hit) ? ST_EMIT : ST_MED_HELD;
            end
            ST_MED_HELD:
            begin
                if (med_stat.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (can_emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next     = count_reg;
        head_next      = head_reg;
        streak_next    = streak_reg;
        lost_next      = lost_reg;
        held_next      = held_reg;
        got_next       = got_reg;
        start_next     = 1'b0;
        seen_next      = seen_reg;
        raw_next       = raw_reg;
        med_next       = med_reg;
        out_state_next = out_state_reg;
        out_mm_next    = out_mm_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = raw_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    seen_next = in_ch.target_seen;
                    raw_next  = in_ch.raw_mm;
                    got_next  = 1'b0;
                    if (has_reading)
                    begin
                        start_next = 1'b1;
                        if (count_reg == '0)
                        begin
                            // empty history: restart at once
                            streak_next = '0;
                            head_next   = '0;
                            count_next  = CNT_W'(1);
                            wr_en       = 1'b1;
                            wr_addr     = '0;
                            wr_data     = in_ch.raw_mm;
                        end
                    end
                end
            end
            ST_MED_CMP:
            begin
                if (med_stat.done)
                begin
                    med_next = med_stat.median;
                end
            end
            ST_JUDGE:
            begin
                if (outlier)
                begin
                    if (streak_hit)
                    begin
                        streak_next = '0;
                        head_next   = '0;
                        count_next  = CNT_W'(1);
                        wr_en       = 1'b1;
                        wr_addr     = '0;
                        start_next  = 1'b1;
                    end
                    else
                    begin
                        streak_next = streak_inc;
                    end
                end
                else
                begin
                    streak_next = '0;
                    wr_en       = 1'b1;
                    start_next  = 1'b1;
                    if (push_full)
                    begin
                        // drop oldest, append at the tail
                        head_next = head_adv;
                        wr_addr   = wrap_add(head_adv, IDX_W'(count_reg - CNT_W'(1)));
                    end
                    else
                    begin
                        count_next = count_p1[CNT_W-1:0];
                        wr_addr    = wrap_add(head_reg, IDX_W'(count_reg));
                    end
                end
            end
            ST_MED_HELD:
            begin
                if (med_stat.done)
                begin
                    held_next = med_stat.median;
                    lost_next = '0;
                    got_next  = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    if (got_reg)
                    begin
                        out_state_next = TRK_TRACK;
                        out_mm_next    = held_reg;
                    end
                    else
                    begin
                        lost_next = lost_inc;
                        if (drop)
                        begin
                            count_next     = '0;
                            streak_next    = '0;
                            held_next      = '0;
                            out_state_next = seen_reg ? TRK_NO_DEPTH : TRK_NO_TARGET;
                            out_mm_next    = '0;
                        end
                        else
                        begin
                            out_state_next = TRK_HOLD;
                            out_mm_next    = held_reg;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            streak_reg    <= '0;
            lost_reg      <= '0;
            held_reg      <= '0;
            got_reg       <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            streak_reg    <= streak_next;
            lost_reg      <= lost_next;
            held_reg      <= held_next;
            got_reg       <= got_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seen_reg      <= seen_next;
        raw_reg       <= raw_next;
        med_reg       <= med_next;
        out_state_reg <= out_state_next;
        out_mm_reg    <= out_mm_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_jump_reg   <= JUMP_W'(300);
            streak_tol_reg <= STREAK_W'(3);
            hist_len_reg   <= LEN_W'(5);
            lost_tol_reg   <= LOST_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MAX_JUMP: max_jump_reg   <= cfg_data[JUMP_W-1:0];
                CFG_STREAK:   streak_tol_reg <= cfg_data[STREAK_W-1:0];
                CFG_HIST_LEN: hist_len_reg   <= cfg_data[LEN_W-1:0];
                CFG_LOST_TOL: lost_tol_reg   <= cfg_data[LOST_W-1:0];
                default:      max_jump_reg   <= max_jump_reg;
            endcase
        end
    end

endmodule

[sv/dom_hist_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dom_hist_ram: history store
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
module dom_hist_ram import dom_pkg::*;
(
    input  logic clk,
    input  logic wr_en,
    input  idx_t wr_addr,
    input  mm_t  wr_data,
    input  idx_t rd_addr_a,
    input  idx_t rd_addr_b,
    output mm_t  rd_data_a,
    output mm_t  rd_data_b
);

    mm_t mem [0:HISTORY_DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

[sv/dom_median.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dom_median: rank-count upper median unit
// One shared compare pair scans every entry against a candidate entry;
// the candidate whose rank range covers count/2 is the median.
// ----------------------------------------------------------------------------
module dom_median import dom_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  med_ctrl_t ctrl,
    output med_stat_t stat,
    output idx_t      rd_addr_a,
    output idx_t      rd_addr_b,
    input  mm_t       rd_data_a,
    input  mm_t       rd_data_b
);

    med_state_t state_reg, state_next;
    idx_t       i_reg, i_next;
    idx_t       j_reg, j_next;
    cnt_t       less_reg, less_next;
    cnt_t       lesseq_reg, lesseq_next;
    logic       done_reg, done_next;
    mm_t        median_reg, median_next;

    cnt_t k;
    logic last_i;
    logic last_j;
    logic found;

    assign k      = ctrl.count >> 1;
    assign last_i = (CNT_W'(i_reg) + CNT_W'(1)) == ctrl.count;
    assign last_j = (CNT_W'(j_reg) + CNT_W'(1)) == ctrl.count;
    assign found  = (less_reg <= k) && (k < lesseq_reg);

    assign rd_addr_a = wrap_add(ctrl.head, i_reg);
    assign rd_addr_b = wrap_add(ctrl.head, j_reg);

    assign stat.done   = done_reg;
    assign stat.median = median_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE:
            begin
                if (ctrl.start && (ctrl.count != '0))
                begin
                    state_next = M_RD;
                end
            end
            M_RD:
            begin
                state_next = M_CMP;
            end
            M_CMP:
            begin
                state_next = last_j ? M_CHECK : M_RD;
            end
            M_CHECK:
            begin
                state_next = (found || last_i) ? M_IDLE : M_RD;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_comb
    begin
        i_next      = i_reg;
        j_next      = j_reg;
        less_next   = less_reg;
        lesseq_next = lesseq_reg;
        done_next   = 1'b0;
        median_next = median_reg;
        unique case (state_reg)
            M_IDLE:
            begin
                if (ctrl.start)
                begin
                    i_next      = '0;
                    j_next      = '0;
                    less_next   = '0;
                    lesseq_next = '0;
                    if (ctrl.count == '0)
                    begin
                        done_next   = 1'b1;
                        median_next = '0;
                    end
                end
            end
            M_RD:
            begin
            end
            M_CMP:
            begin
                less_next   = less_reg + CNT_W'(rd_data_b < rd_data_a);
                lesseq_next = lesseq_reg + CNT_W'(rd_data_b <= rd_data_a);
                if (!last_j)
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            M_CHECK:
            begin
                if (found)
                begin
                    done_next   = 1'b1;
                    median_next = rd_data_a;
                end
                else if (last_i)
                begin
                    done_next   = 1'b1;
                    median_next = '0;
                end
                else
                begin
                    i_next      = i_reg + IDX_W'(1);
                    j_next      = '0;
                    less_next   = '0;
                    lesseq_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= M_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            less_reg   <= '0;
            lesseq_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            less_reg   <= less_next;
            lesseq_reg <= lesseq_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg <= median_next;
    end

endmodule

[sim/dom_track_compare.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dom_track_compare: result prediction and comparison for the depth tracker
// Watches the frame and result channels and the register write port, keeps
// its own copy of the depth history, outlier streak, lost-frame count and
// held distance, predicts the track state and filtered distance of every
// accepted frame and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module dom_track_compare import dom_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    dom_in_if                     in_ch,
    dom_out_if                    out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    checked
);

    typedef struct packed {
        trk_state_t st;
        mm_t        mm;
    } track_rec_t;

    track_rec_t pending_tracks[$];

    logic [JUMP_W-1:0]   jump_lim;
    logic [STREAK_W-1:0] streak_lim;
    logic [LEN_W-1:0]    len_cfg;
    logic [LOST_W-1:0]   lost_tol;

    mm_t hist[HISTORY_DEPTH];
    int  hist_n;
    int  streak_n;
    int  lost_n;
    mm_t held;

    function automatic int len_eff();
        int n;
        n = int'(len_cfg);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > HISTORY_DEPTH)
        begin
            n = HISTORY_DEPTH;
        end
        return n;
    endfunction

    // upper median: the entry whose ascending rank covers count/2
    function automatic mm_t hist_median();
        int k;
        int less;
        int leq;
        k = hist_n / 2;
        for (int i = 0; i < hist_n && i < HISTORY_DEPTH; i++)
        begin
            less = 0;
            leq  = 0;
            for (int j = 0; j < hist_n && j < HISTORY_DEPTH; j++)
            begin
                if (hist[j] < hist[i])
                begin
                    less++;
                end
                if (hist[j] <= hist[i])
                begin
                    leq++;
                end
            end
            if (less <= k && k < leq)
            begin
                return hist[i];
            end
        end
        return '0;
    endfunction

    function automatic void hist_restart(mm_t v);
        hist[0] = v;
        hist_n  = 1;
    endfunction

    // full (or over-full after a length change): drop only the oldest entry
    function automatic void hist_push(mm_t v);
        int n;
        if (hist_n + 1 > len_eff() || hist_n >= HISTORY_DEPTH)
        begin
            n = (hist_n > HISTORY_DEPTH) ? HISTORY_DEPTH : hist_n;
            if (n == 0)
            begin
                hist_restart(v);
            end
            else
            begin
                for (int i = 0; i + 1 < n; i++)
                begin
                    hist[i] = hist[i + 1];
                end
                hist[n - 1] = v;
                hist_n      = n;
            end
        end
        else
        begin
            hist[hist_n] = v;
            hist_n++;
        end
    endfunction

    function automatic logic take_reading(mm_t v);
        mm_t med;
        int  diff;
        if (hist_n == 0)
        begin
            streak_n = 0;
            hist_restart(v);
            return 1'b1;
        end
        med  = hist_median();
        diff = int'(v) - int'(med);
        if (diff < 0)
        begin
            diff = -diff;
        end
        if (diff > int'(jump_lim))
        begin
            if (streak_n < 255)
            begin
                streak_n++;
            end
            if (streak_n >= int'(streak_lim))
            begin
                streak_n = 0;
                hist_restart(v);
                return 1'b1;
            end
            return 1'b0;
        end
        streak_n = 0;
        hist_push(v);
        return 1'b1;
    endfunction

    function automatic track_rec_t filter_frame(logic seen, logic rv, mm_t raw);
        track_rec_t r;
        logic       got;
        got = 1'b0;
        if (seen && rv)
        begin
            got = take_reading(raw);
        end
        if (got)
        begin
            lost_n = 0;
            held   = hist_median();
            r.st   = TRK_TRACK;
        end
        else
        begin
            if (lost_n < 255)
            begin
                lost_n++;
            end
            if (lost_n >= int'(lost_tol) || held == '0)
            begin
                hist_n   = 0;
                streak_n = 0;
                held     = '0;
                r.st     = seen ? TRK_NO_DEPTH : TRK_NO_TARGET;
            end
            else
            begin
                r.st = TRK_HOLD;
            end
        end
        r.mm = held;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        track_rec_t want;
        int         bad;
        if (!rst_n)
        begin
            jump_lim   = 16'd300;
            streak_lim = 8'd3;
            len_cfg    = 4'd5;
            lost_tol   = 8'd10;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist[i] = '0;
            end
            hist_n   = 0;
            streak_n = 0;
            lost_n   = 0;
            held     = '0;
            pending_tracks.delete();
            errors  <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            bad = 0;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MAX_JUMP: jump_lim   = cfg_data[JUMP_W-1:0];
                    CFG_STREAK:   streak_lim = cfg_data[STREAK_W-1:0];
                    CFG_HIST_LEN: len_cfg    = cfg_data[LEN_W-1:0];
                    CFG_LOST_TOL: lost_tol   = cfg_data[LOST_W-1:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                checked <= checked + 1;
                if (pending_tracks.size() == 0)
                begin
                    $display("%0t: result with no request outstanding: %s %0d mm %0d",
                             $time, "expected none, got state",
                             out_ch.track_state, out_ch.filtered_mm);
                    bad++;
                end
                else
                begin
                    want = pending_tracks[0];
                    pending_tracks.delete(0);
                    if (out_ch.track_state !== want.st)
                    begin
                        $display("%0t: track_state expected %0d, got %0d",
                                 $time, want.st, out_ch.track_state);
                        bad++;
                    end
                    if (out_ch.filtered_mm !== want.mm)
                    begin
                        $display("%0t: filtered_mm expected %0d, got %0d",
                                 $time, want.mm, out_ch.filtered_mm);
                        bad++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                pending_tracks.insert(pending_tracks.size(),
                                      filter_frame(in_ch.target_seen, in_ch.reading_valid,
                                                   in_ch.raw_mm));
            end
            errors  <= errors + bad;
            pending <= int'(pending_tracks.size());
        end
    end

endmodule

[sim/tb_depth_outlier_median_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_outlier_median_tracker: testbench of the depth outlier tracker
// Drives frame requests with random gaps and result stalls, walks through
// several register settings including both extremes, runs a short directed
// sequence, a long outlier streak and random tracking sequences, and lets
// dom_track_compare predict and check every result.
// ----------------------------------------------------------------------------
module tb_depth_outlier_median_tracker;
    import dom_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int GAP_MAX     = 18;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int  errors;
    int  pending;
    int  checked;
    int  cycles   = 0;
    int  frames   = 0;
    int  settings = 0;
    int  rx_hold  = 0;
    bit  quiet    = 1'b0;
    int  cur_jump = 300;
    mm_t base     = 16'd1000;

    dom_in_if  in_ch ();
    dom_out_if out_ch ();

    depth_outlier_median_tracker dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dom_track_compare u_compare
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stall before each result, or a long hold-off on request
    initial
    begin
        int stall;
        out_ch.ready <= 1'b1;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            else
            begin
                stall = quiet ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    task automatic offer(input logic seen, input logic rv, input mm_t raw);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.target_seen   <= seen;
        in_ch.reading_valid <= rv;
        in_ch.raw_mm        <= raw;
        do @(posedge clk); while (!in_ch.ready);
        frames++;
    endtask

    // stop offering and wait until every result is back
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic program_cfg(input logic [15:0] jump, input logic [7:0] streak,
                               input logic [3:0] len, input logic [7:0] lost);
        cfg_idx_t              regs[4];
        logic [CFG_DATA_W-1:0] vals[4];
        regs = '{CFG_MAX_JUMP, CFG_STREAK, CFG_HIST_LEN, CFG_LOST_TOL};
        vals = '{jump, 16'(streak), 16'(len), 16'(lost)};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we   <= 1'b0;
        cur_jump = int'(jump);
        settings++;
    endtask

    // target tracked at a slowly moving distance, with outliers and dropouts
    task automatic frame_seq(input int n);
        int r;
        int v;
        int d;
        for (int i = 0; i < n; i++)
        begin
            if (i % 20 == 0)
            begin
                case ($urandom_range(0, 7))
                    0:       base = 16'd0;
                    1:       base = 16'hFFFF;
                    default: base = mm_t'($urandom);
                endcase
                quiet = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                case ($urandom_range(0, 5))
                    0, 1: d = 0;
                    2:    d = int'($urandom_range(0, 2 * cur_jump)) - cur_jump;
                    3:    d = cur_jump;
                    4:    d = -cur_jump;
                    default: d = $urandom_range(0, 1) ? cur_jump + 1 : -(cur_jump + 1);
                endcase
                v = int'(base) + d;
                offer(1'b1, 1'b1, (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : mm_t'(v));
            end
            else if (r < 70)
            begin
                offer(1'b1, 1'b1, mm_t'($urandom));
            end
            else if (r < 80)
            begin
                offer(1'b1, 1'b0, mm_t'($urandom));
            end
            else if (r < 90)
            begin
                offer(1'b0, 1'($urandom_range(0, 1)), mm_t'($urandom));
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       offer(1'b1, 1'b1, 16'd0);
                    1:       offer(1'b1, 1'b1, 16'hFFFF);
                    default: offer(1'b1, 1'b1, base);
                endcase
            end
        end
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.target_seen   <= 1'b0;
        in_ch.reading_valid <= 1'b0;
        in_ch.raw_mm        <= '0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_MAX_JUMP;
        cfg_data            <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings: jump 300, streak 3, length 5, tolerance 10
        offer(1'b0, 1'b0, 16'd0);
        offer(1'b1, 1'b0, 16'h1234);
        offer(1'b0, 1'b1, 16'd1000);
        offer(1'b1, 1'b1, 16'd1000);
        offer(1'b1, 1'b1, 16'd1300);
        offer(1'b1, 1'b1, 16'd999);
        offer(1'b1, 1'b1, 16'hFFFF);
        offer(1'b1, 1'b1, 16'hFFFF);
        offer(1'b1, 1'b0, 16'd0);
        offer(1'b0, 1'b0, 16'd0);
        offer(1'b1, 1'b1, 16'd0);
        repeat (7) offer(1'b0, 1'b0, mm_t'($urandom));
        offer(1'b1, 1'b1, 16'd0);
        offer(1'b1, 1'b0, 16'd0);
        offer(1'b1, 1'b1, 16'hFFFF);
        settle();

        // long outlier run up to the largest streak and tolerance
        program_cfg(16'd0, 8'd255, 4'd1, 8'd255);
        quiet = 1'b1;
        offer(1'b1, 1'b1, 16'd1000);
        repeat (256) offer(1'b1, 1'b1, 16'd5000);
        quiet = 1'b0;
        settle();

        program_cfg(16'd0, 8'd0, 4'd0, 8'd0);
        frame_seq(70);
        settle();
        program_cfg(16'hFFFF, 8'hFF, 4'hF, 8'hFF);
        frame_seq(70);
        settle();

        // result side held off while requests keep coming, then a full pause
        program_cfg(16'd50, 8'd1, 4'd8, 8'd3);
        frame_seq(40);
        rx_hold = 500;
        frame_seq(30);
        settle();
        frame_seq(30);
        settle();

        // fill a long history, then shorten it
        program_cfg(16'd200, 8'd4, 4'd8, 8'd20);
        frame_seq(70);
        quiet = 1'b0;
        repeat (8) offer(1'b1, 1'b1, base);
        settle();
        program_cfg(16'd200, 8'd4, 4'd2, 8'd20);
        frame_seq(70);
        settle();
        program_cfg(16'd1000, 8'd2, 4'd9, 8'd1);
        frame_seq(70);

        for (int p = 0; p < 3; p++)
        begin
            settle();
            program_cfg(($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000)),
                        8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                        8'($urandom_range(0, 255)));
            frame_seq(70);
        end

        settle();
        repeat (300) @(posedge clk);
        $display("Covered %0d frames under %0d register settings, %0d results compared",
                 frames, settings, checked);
        if (errors == 0 && pending == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
